[hw/rtl/smmu_pkg.sv]
// Shared constants, types and helpers for the square matrix multiply unit.
// No dependencies; imported by every module of the block.
package smmu_pkg;

    // Matrix geometry
    localparam int MAX_SIZE = 16;
    localparam int IDX_W    = 4;
    localparam int SIZE_W   = 5;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_SIZE * MAX_SIZE;

    // Datapath widths
    localparam int ELEM_W = 32;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = PROD_W + 4;

    // Stream payload widths
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;

    // Request kinds carried in tuser
    localparam logic [IN_USER_W-1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [IN_USER_W-1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [IN_USER_W-1:0] FUNC_ROW    = 2'd2;

    // Register index of the size register
    localparam logic REG_SIZE = 1'b0;

    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    // Control that travels with one multiply-accumulate term
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

    // Clamp the exact sum to the signed 64-bit range
    function automatic logic [PROD_W-1:0] sat_sum(input logic [ACC_W-1:0] sum);
        logic [PROD_W-1:0] res;
        res = sum[PROD_W-1:0];
        if (!sum[ACC_W-1] && (|sum[ACC_W-2:PROD_W-1])) begin
            res = {1'b0, {(PROD_W-1){1'b1}}};
        end else if (sum[ACC_W-1] && !(&sum[ACC_W-2:PROD_W-1])) begin
            res = {1'b1, {(PROD_W-1){1'b0}}};
        end
        return res;
    endfunction

endpackage

[hw/rtl/smmu_ram.sv]
// Element store: one write port, one read port with registered read data.
// Depends on smmu_pkg for depth and widths.
module smmu_ram
    import smmu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [ELEM_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [ELEM_W-1:0] o_rdata
);

    logic [ELEM_W-1:0] r_mem [DEPTH];
    logic [ELEM_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the read data is registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/smmu_mac.sv]
// Multiply-accumulate datapath: registered product, exact wide sum, saturation.
// Depends on smmu_pkg; fed by the element stores and the sequencer.
module smmu_mac
    import smmu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_ctl          i_ctl,
    input  logic [ELEM_W-1:0] i_a,
    input  logic [ELEM_W-1:0] i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_result
);

    t_mac_ctl          r_rd_ctl;
    t_mac_ctl          r_mul_ctl;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic              r_done;
    logic [ACC_W-1:0]  prod_ext;

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // Control follows the data through the read and multiply stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ctl  <= '0;
            r_mul_ctl <= '0;
            r_done    <= 1'b0;
        end else begin
            r_rd_ctl  <= i_ctl;
            r_mul_ctl <= r_rd_ctl;
            r_done    <= r_mul_ctl.vld && r_mul_ctl.last;
        end
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'($signed(i_a) * $signed(i_b));
    end

    // Accumulate; hold the sum after the last term until the next first term
    always_ff @(posedge i_clk) begin
        if (r_mul_ctl.vld) begin
            r_acc <= r_mul_ctl.first ? prod_ext : r_acc + prod_ext;
        end
    end

    assign o_done   = r_done;
    assign o_result = sat_sum(r_acc);

endmodule

[hw/rtl/smmu_seq.sv]
// Request sequencer: decodes requests, drives store addresses, walks k and j
// for a row of C and holds the output register. Depends on smmu_pkg.
module smmu_seq
    import smmu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [SIZE_W-1:0]     i_size,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast,
    output logic                  o_a_we,
    output logic                  o_b_we,
    output logic [ADDR_W-1:0]     o_waddr,
    output logic [ELEM_W-1:0]     o_wdata,
    output logic [ADDR_W-1:0]     o_a_raddr,
    output logic [ADDR_W-1:0]     o_b_raddr,
    output t_mac_ctl              o_iss,
    input  logic                  i_mac_done,
    input  logic [PROD_W-1:0]     i_mac_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_PUSH
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_row, n_row;
    logic [IDX_W-1:0]  r_col, n_col;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [SIZE_W-1:0] r_n, n_n;
    logic              r_out_vld, n_out_vld;
    logic [IDX_W-1:0]  r_out_row, n_out_row;
    logic [IDX_W-1:0]  r_out_col, n_out_col;
    logic [PROD_W-1:0] r_out_val, n_out_val;
    logic              r_out_last, n_out_last;

    logic [IDX_W-1:0]  in_row;
    logic [IDX_W-1:0]  in_col;
    logic              in_acc;
    logic              in_rng;
    logic              k_last;
    logic              col_last;

    // Request decode
    assign in_row = i_s_tdata[IDX_W-1:0];
    assign in_col = i_s_tdata[2*IDX_W-1:IDX_W];
    assign in_acc = i_s_tvalid && o_s_tready;
    assign in_rng = ({1'b0, in_row} < i_size) && ({1'b0, in_col} < i_size);

    assign o_s_tready = (r_state == S_IDLE);

    // Element loads go straight into the stores
    assign o_a_we  = in_acc && (i_s_tuser == FUNC_LOAD_A) && in_rng;
    assign o_b_we  = in_acc && (i_s_tuser == FUNC_LOAD_B) && in_rng;
    assign o_waddr = {in_row, in_col};
    assign o_wdata = i_s_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];

    // Read A[row][k] and B[k][col]
    assign o_a_raddr   = {r_row, r_k};
    assign o_b_raddr   = {r_k, r_col};
    assign o_iss.vld   = (r_state == S_RUN);
    assign o_iss.first = (r_k == '0);
    assign o_iss.last  = k_last;

    assign k_last   = ({1'b0, r_k} == r_n - SIZE_W'(1));
    assign col_last = ({1'b0, r_col} == r_n - SIZE_W'(1));

    // Next state
    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_k        = r_k;
        n_n        = r_n;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_val  = r_out_val;
        n_out_last = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_s_tuser == FUNC_ROW) && ({1'b0, in_row} < i_size)) begin
                    n_row   = in_row;
                    n_col   = '0;
                    n_k     = '0;
                    n_n     = i_size;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (k_last) begin
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_WAIT: begin
                if (i_mac_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                // Load the result once the output register frees up
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_row  = r_row;
                    n_out_col  = r_col;
                    n_out_val  = i_mac_result;
                    n_out_last = col_last;
                    if (col_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_col   = r_col + IDX_W'(1);
                        n_k     = '0;
                        n_state = S_RUN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_vld  <= n_out_vld;
            r_row      <= n_row;
            r_col      <= n_col;
            r_k        <= n_k;
            r_n        <= n_n;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_out_val  <= n_out_val;
            r_out_last <= n_out_last;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_val, r_out_col, r_out_row};
    assign o_m_tlast  = r_out_last;

endmodule

[hw/rtl/square_matrix_multiply_unit.sv]
// Square matrix multiply unit, C = A * B, with A and B held in two on-chip
// element stores of 16x16 signed Q16.16 words. A request either loads one
// element or asks for one row of C; a row request with size n streams n
// saturated Q32.32 dot products, column by column, the last one marked by
// tlast. One shared multiply-accumulate unit reads one term of A and one of
// B per cycle while a column is summed, then the sum passes through read,
// multiply, accumulate and output load; a full output register holds back the
// next column. Input is stalled while a row is in progress. The stores are
// not cleared at reset; elements must be loaded before a row that uses them.
// Depends on smmu_pkg, smmu_ram, smmu_mac and smmu_seq.
module square_matrix_multiply_unit
    import smmu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // row_index[3:0], col_index[7:4],
                                              // element_value[39:8]
    input  logic [IN_USER_W-1:0]  i_s_tuser,  // func[1:0]
    // Result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,  // out_row[3:0], out_col[7:4],
                                              // product_value[71:8]
    output logic                  o_m_tlast,  // last_of_row
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] size_eff;
    logic              cfg_wr;

    logic              a_we, b_we;
    logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;
    logic [ELEM_W-1:0] wdata, a_rdata, b_rdata;
    t_mac_ctl          iss;
    logic              mac_done;
    logic [PROD_W-1:0] mac_result;

    // Size register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (cfg_wr) begin
            r_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign prdata   = (paddr[2] == REG_SIZE) ? {{(32-SIZE_W){1'b0}}, r_size} : '0;
    assign size_eff = (r_size > SIZE_MAX) ? SIZE_MAX : r_size;

    smmu_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_size       (size_eff),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tlast    (o_m_tlast),
        .o_a_we       (a_we),
        .o_b_we       (b_we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_a_raddr    (a_raddr),
        .o_b_raddr    (b_raddr),
        .o_iss        (iss),
        .i_mac_done   (mac_done),
        .i_mac_result (mac_result)
    );

    smmu_ram u_ram_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    smmu_ram u_ram_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    smmu_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (iss),
        .i_a      (a_rdata),
        .i_b      (b_rdata),
        .o_done   (mac_done),
        .o_result (mac_result)
    );

    // A valid row request closes the input on the next cycle
    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == FUNC_ROW)
         && ({1'b0, i_s_tdata[IDX_W-1:0]} < size_eff)) |=> !o_s_tready)
        else $error("input open after a row request");

    // A finished dot product only appears while a row is in progress
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> !o_s_tready)
        else $error("dot product finished while idle");

    // Store writes only on accepted loads, never to both stores
    a_store_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_we || b_we) |-> (i_s_tvalid && o_s_tready && !(a_we && b_we)))
        else $error("unexpected store write");

endmodule

[bench/square_matrix_multiply_unit_tb.sv]
// Testbench for the square matrix multiply unit: element loads, row requests
// and size register writes, products checked against a model or typed values.
// Depends on smmu_pkg and square_matrix_multiply_unit.
`timescale 1ns / 1ps

module square_matrix_multiply_unit_tb;
    import smmu_pkg::*;

    // Codes and limits local to the bench
    localparam logic [1:0] FUNC_NONE    = 2'd3;
    localparam logic [2:0] ADDR_SIZE    = {REG_SIZE, 2'b00};
    localparam logic [2:0] ADDR_SPARE   = 3'd4;
    localparam int         ITEM_TARGET  = 430;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         STALL_LIMIT  = 5000;

    localparam logic [31:0] E_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] E_MIN = 32'h8000_0000;
    localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;
    localparam logic signed [71:0] ACC_MAX = 72'sh00_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [71:0] ACC_MIN = 72'shFF_8000_0000_0000_0000;
    localparam logic [2:0][63:0]   NO_TYPED = '0;

    // One product as it leaves the block
    typedef struct packed {
        logic [3:0]  row;
        logic [3:0]  col;
        logic [63:0] value;
        logic        last;
    } product_t;

    // One step of the directed sequence: a register write or a request
    typedef struct packed {
        logic             cfg;
        logic [2:0]       addr;
        logic [1:0]       func;
        logic [3:0]       row;
        logic [3:0]       col;
        logic [31:0]      value;
        logic [1:0]       n_typed;  // products typed in below; 0: use the model
        logic [2:0][63:0] typed;    // column j in typed[j]
    } plan_row_t;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;   // row_index[3:0], col_index[7:4],
                                              // element_value[39:8]
    logic [IN_USER_W-1:0]  i_s_tuser  = '0;   // func[1:0]
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;         // out_row[3:0], out_col[7:4],
                                              // product_value[71:8]
    logic                  o_m_tlast;         // last_of_row
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [2:0]            paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Local copy of the stores and the size register
    logic signed [31:0] a_elem [MAX_SIZE][MAX_SIZE];
    logic signed [31:0] b_elem [MAX_SIZE][MAX_SIZE];
    bit                 a_set  [MAX_SIZE][MAX_SIZE];
    bit                 b_set  [MAX_SIZE][MAX_SIZE];
    logic [4:0]         size_cfg = SIZE_RESET;

    product_t pending_products [$];
    int       errors         = 0;
    int       accepted_items = 0;
    int       stall_cycles   = 0;
    bit       no_idle        = 1'b0;

    plan_row_t plan [29] = '{
        // size 1: extreme single terms
        '{1'b1, ADDR_SIZE, FUNC_NONE,   4'd0,  4'd0,  32'd1, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_A, 4'd0,  4'd0,  E_MIN, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_B, 4'd0,  4'd0,  E_MIN, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_ROW,    4'd0,  4'd0,  32'd0, 2'd1,
          {128'h0, 64'h4000_0000_0000_0000}},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_B, 4'd0,  4'd0,  E_MAX, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_ROW,    4'd0,  4'd0,  32'd0, 2'd1,
          {128'h0, 64'hC000_0000_8000_0000}},
        // out of range and unused code: no product
        '{1'b0, ADDR_SIZE, FUNC_LOAD_A, 4'd1,  4'd0,  32'h1234_5678, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_B, 4'd0,  4'd15, 32'hDEAD_BEEF, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_ROW,    4'd1,  4'd0,  32'd0, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_NONE,   4'd0,  4'd0,  32'hFFFF_FFFF, 2'd0, NO_TYPED},
        // write to a register that does not exist: size stays 1
        '{1'b1, ADDR_SPARE, FUNC_NONE,  4'd0,  4'd0,  32'd3, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_ROW,    4'd0,  4'd0,  32'd0, 2'd1,
          {128'h0, 64'hC000_0000_8000_0000}},
        // size zero: everything ignored
        '{1'b1, ADDR_SIZE, FUNC_NONE,   4'd0,  4'd0,  32'd0, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_A, 4'd0,  4'd0,  32'hFFFF_FFFF, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_ROW,    4'd15, 4'd15, 32'd0, 2'd0, NO_TYPED},
        // size 3: saturate high, saturate low, zero
        '{1'b1, ADDR_SIZE, FUNC_NONE,   4'd0,  4'd0,  32'd3, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_A, 4'd0,  4'd0,  E_MIN, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_A, 4'd0,  4'd1,  E_MIN, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_A, 4'd0,  4'd2,  E_MIN, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_B, 4'd0,  4'd0,  E_MIN, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_B, 4'd1,  4'd0,  E_MIN, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_B, 4'd2,  4'd0,  E_MIN, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_B, 4'd0,  4'd1,  E_MAX, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_B, 4'd1,  4'd1,  E_MAX, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_B, 4'd2,  4'd1,  E_MAX, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_B, 4'd0,  4'd2,  32'd0, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_B, 4'd1,  4'd2,  32'd0, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_LOAD_B, 4'd2,  4'd2,  32'd0, 2'd0, NO_TYPED},
        '{1'b0, ADDR_SIZE, FUNC_ROW,    4'd0,  4'd0,  32'd0, 2'd3, {64'h0, Q_MIN, Q_MAX}}
    };

    square_matrix_multiply_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Size in effect: values above the store size act as the store size
    function automatic int size_in_effect();
        return (size_cfg > MAX_SIZE) ? MAX_SIZE : int'(size_cfg);
    endfunction

    // Exact dot product of row r of A and column c of B, clamped to 64 bits
    function automatic logic [63:0] dot_row_col(input int r, input int c, input int n);
        logic signed [71:0] acc;
        logic signed [63:0] term;
        acc = '0;
        for (int k = 0; k < n; k++) begin
            term = a_elem[r][k] * b_elem[k][c];
            acc  = acc + term;
        end
        if (acc > ACC_MAX) return Q_MAX;
        if (acc < ACC_MIN) return Q_MIN;
        return acc[63:0];
    endfunction

    // Element values leaning on the extremes
    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return E_MAX;
            1: return E_MIN;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    // Hold off the sender until every product is in and the pipe is empty
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register while idle, then read the size register back
    task automatic reg_write_readback(input logic [2:0] addr, input logic [31:0] value);
        wait_idle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_SIZE) size_cfg = value[4:0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_SIZE;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(size_cfg)) begin
            $display("%0t: size register expected %0d, got %0d", $time, size_cfg, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Send one request and update the model once it is accepted
    task automatic send_request(input logic [1:0] func, input logic [3:0] row,
                                input logic [3:0] col, input logic [31:0] value,
                                input logic [1:0] n_typed = 2'd0,
                                input logic [2:0][63:0] typed = '0);
        int       n;
        bit       is_load;
        product_t p;
        n       = size_in_effect();
        is_load = (func == FUNC_LOAD_A || func == FUNC_LOAD_B);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 20) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {value, col, row};
        do @(posedge i_clk); while (!o_s_tready);

        if (n_typed != 0) begin
            for (int j = 0; j < n_typed; j++) begin
                p = '{row, 4'(j), typed[j], j == n_typed - 1};
                pending_products.push_back(p);
            end
        end else if (is_load && row < n && col < n) begin
            if (func == FUNC_LOAD_A) begin
                a_elem[row][col] = value;
                a_set[row][col]  = 1'b1;
            end else begin
                b_elem[row][col] = value;
                b_set[row][col]  = 1'b1;
            end
        end else if (func == FUNC_ROW && row < n) begin
            for (int j = 0; j < n; j++) begin
                p = '{row, 4'(j), dot_row_col(row, j, n), j == n - 1};
                pending_products.push_back(p);
            end
        end
        accepted_items++;
        no_idle = (accepted_items >= 200 && accepted_items < 280);
    endtask

    // Result side backpressure
    always @(negedge i_clk) begin
        i_m_tready <= no_idle || ($urandom_range(0, 99) >= 20);
    end

    // Check each product against the oldest expectation
    always @(posedge i_clk) begin : check_products
        product_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_products.size() == 0) begin
                $display("%0t: unexpected product row %0d col %0d value %h", $time,
                         o_m_tdata[3:0], o_m_tdata[7:4], o_m_tdata[71:8]);
                errors++;
            end else begin
                want = pending_products.pop_front();
                if (o_m_tdata[3:0] !== want.row) begin
                    $display("%0t: out_row expected %0d, got %0d", $time, want.row,
                             o_m_tdata[3:0]);
                    errors++;
                end
                if (o_m_tdata[7:4] !== want.col) begin
                    $display("%0t: out_col expected %0d, got %0d", $time, want.col,
                             o_m_tdata[7:4]);
                    errors++;
                end
                if (o_m_tdata[71:8] !== want.value) begin
                    $display("%0t: product_value expected %h, got %h", $time, want.value,
                             o_m_tdata[71:8]);
                    errors++;
                end
                if (o_m_tlast !== want.last) begin
                    $display("%0t: last_of_row expected %0b, got %0b", $time, want.last,
                             o_m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int         phase;
        int         quota;
        int         pick;
        int         n;
        int         rr;
        logic [4:0] size_pick;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sequence
        foreach (plan[i]) begin
            if (plan[i].cfg) begin
                reg_write_readback(plan[i].addr, plan[i].value);
            end else begin
                send_request(plan[i].func, plan[i].row, plan[i].col, plan[i].value,
                             plan[i].n_typed, plan[i].typed);
            end
        end

        // Random phases, each at its own matrix size; full and clamped sizes early
        phase = 0;
        while (accepted_items < ITEM_TARGET || phase < 4) begin
            case (phase)
                1: size_pick = 5'd16;
                2: size_pick = 5'd31;
                3: size_pick = 5'($urandom_range(17, 30));
                default: begin
                    if ($urandom_range(0, 9) == 0)
                        size_pick = 5'd0;
                    else if ($urandom_range(0, 4) == 0)
                        size_pick = 5'($urandom_range(6, 10));
                    else
                        size_pick = 5'($urandom_range(1, 5));
                end
            endcase
            reg_write_readback(ADDR_SIZE, 32'(size_pick));
            n = size_in_effect();
            // Keep full-size phases short: the first row there loads all of B
            if (n == 0)
                quota = 8;
            else if (n >= MAX_SIZE)
                quota = $urandom_range(3, 6);
            else
                quota = $urandom_range(20, 40);
            for (int i = 0; i < quota; i++) begin
                if (phase == 2 && i == quota / 2) wait_idle();
                pick = (n == 0) ? 99 : $urandom_range(0, 99);
                if (pick < 45) begin
                    // overwrite one element in range
                    send_request(($urandom_range(0, 1) == 0) ? FUNC_LOAD_A : FUNC_LOAD_B,
                                 4'($urandom_range(0, n - 1)), 4'($urandom_range(0, n - 1)),
                                 rand_elem());
                end else if (pick < 80) begin
                    // load whatever the row still lacks, then ask for it
                    rr = $urandom_range(0, n - 1);
                    for (int k = 0; k < n; k++) begin
                        if (!a_set[rr][k])
                            send_request(FUNC_LOAD_A, 4'(rr), 4'(k), rand_elem());
                    end
                    for (int k = 0; k < n; k++) begin
                        for (int j = 0; j < n; j++) begin
                            if (!b_set[k][j])
                                send_request(FUNC_LOAD_B, 4'(k), 4'(j), rand_elem());
                        end
                    end
                    send_request(FUNC_ROW, 4'(rr), 4'($urandom), $urandom);
                end else begin
                    // requests the block drops
                    case ((n >= MAX_SIZE) ? 3 : $urandom_range(0, 3))
                        0: send_request(FUNC_LOAD_A, 4'($urandom_range(n, 15)), 4'($urandom),
                                        rand_elem());
                        1: send_request(FUNC_LOAD_B, 4'($urandom), 4'($urandom_range(n, 15)),
                                        rand_elem());
                        2: send_request(FUNC_ROW, 4'($urandom_range(n, 15)), 4'($urandom),
                                        $urandom);
                        default: send_request(FUNC_NONE, 4'($urandom), 4'($urandom),
                                              $urandom);
                    endcase
                end
            end
            phase++;
        end

        wait_idle();
        if (errors == 0 && pending_products.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/smmu_pkg.sv
hw/rtl/smmu_ram.sv
hw/rtl/smmu_mac.sv
hw/rtl/smmu_seq.sv
hw/rtl/square_matrix_multiply_unit.sv
bench/square_matrix_multiply_unit_tb.sv
